>>> hdl/fclp_pkg.sv
`timescale 1ns / 1ps

package fclp_pkg;

   localparam int WORD_COUNT = 36;
   localparam int FQ_DEPTH   = 4;
   localparam int FQ_AW      = 2;
   localparam int OQ_DEPTH   = 2;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MORE = 2'd1,
      ST_FAIL = 2'd2,
      ST_LONG = 2'd3
   } fclp_status_type;

   typedef enum logic [1:0] {
      PH_WORD  = 2'b01,
      PH_PARAM = 2'b10
   } fclp_phase_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       final_byte;
      logic       is_space;
      logic       is_cr;
      logic       is_ws;
   } fclp_item_type;

   typedef struct packed {
      logic            param_valid;
      logic [7:0]      param_byte;
      logic [7:0]      param_index;
      logic            done_res;
      fclp_status_type status;
      logic [5:0]      command_code;
      logic [8:0]      param_length;
   } fclp_result_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] code;
   } fclp_match_type;

   localparam logic [31:0] CMD_WORD [WORD_COUNT] = '{
      "USER", "PASS", "PWD",  "CWD",  "LIST", "NLST", "PASV", "RETR", "STOR",
      "PORT", "TYPE", "MODE", "QUIT", "ABOR", "DELE", "RMD",  "XRMD", "MKD",
      "XMKD", "XPWD", "SYST", "REST", "RNFR", "RNTO", "STAT", "NOOP", "MDTM",
      "SIZE", "SITE", "FEAT", "OPTS", "feat", "opts", "syst", "site", "noop"
   };

   localparam logic [2:0] CMD_LEN [WORD_COUNT] = '{
      3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
   };

   function automatic fclp_match_type fclp_lookup(input logic [31:0] word,
                                                  input logic [2:0]  len);
      fclp_match_type m;
      m = '0;
      for (int i = 0; i < WORD_COUNT; i++) begin
         if (!m.hit && len == CMD_LEN[i] && word == CMD_WORD[i]) begin
            m.hit  = 1'b1;
            m.code = 6'(i);
         end
      end
      return m;
   endfunction

endpackage

>>> hdl/fclp_front.sv
`timescale 1ns / 1ps

module fclp_front import fclp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    line_byte,
   input  logic          final_byte,
   input  logic          push,
   output logic          full,
   output logic          q_valid,
   output fclp_item_type q_item,
   input  logic          q_pop
);

   fclp_item_type        mem_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]     wr_ff, wr_in;
   logic [FQ_AW-1:0]     rd_ff, rd_in;
   logic [FQ_AW:0]       count_ff, count_in;
   fclp_item_type        item;
   logic                 push_fire;
   logic                 pop_fire;

   always_comb begin
      item.line_byte  = line_byte;
      item.final_byte = final_byte;
      item.is_space   = (line_byte == CHAR_SPACE);
      item.is_cr      = (line_byte == CHAR_CR);
      item.is_ws      = (line_byte == CHAR_SPACE) || (line_byte == CHAR_CR)
                        || (line_byte == CHAR_LF);
   end

   assign full      = (count_ff == (FQ_AW+1)'(FQ_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ff];
   assign push_fire = push && !full;
   assign pop_fire  = q_pop && q_valid;

   always_comb begin
      wr_in    = push_fire ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop_fire ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (FQ_AW+1)'(push_fire) - (FQ_AW+1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/fclp_back.sv
`timescale 1ns / 1ps

module fclp_back import fclp_pkg::*; #(
   parameter int PARAM_MAX = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  fclp_item_type   q_item,
   output logic            q_pop,
   output logic            empty,
   input  logic            pop,
   output fclp_result_type result
);

   localparam int PW = $clog2(PARAM_MAX + 2);
   localparam logic [PW-1:0] PMAX      = PW'(PARAM_MAX);
   localparam logic [PW-1:0] PMAX_PLUS = PW'(PARAM_MAX + 1);

   fclp_phase_type  phase_ff, phase_in;
   logic [31:0]     shift_ff, shift_in;
   logic [2:0]      wlen_ff, wlen_in;
   logic [2:0]      seen_ff, seen_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [PW-1:0]   trim_ff, trim_in;
   logic [5:0]      code_ff, code_in;
   logic            fail_ff, fail_in;

   fclp_result_type oq_ff [OQ_DEPTH];
   logic            owr_ff, owr_in;
   logic            ord_ff, ord_in;
   logic [1:0]      ocnt_ff, ocnt_in;

   fclp_result_type res;
   fclp_match_type  match;
   logic            take;
   logic            out_pop;
   logic            at_four;
   logic            success;
   logic [PW:0]     pos_inc;
   logic [PW+8:0]   pos_wide;
   logic [PW+8:0]   trim_wide;

   assign empty   = (ocnt_ff == 2'd0);
   assign result  = oq_ff[ord_ff];
   assign out_pop = pop && !empty;
   assign q_pop   = q_valid && ((ocnt_ff != 2'(OQ_DEPTH)) || out_pop);
   assign match   = fclp_lookup(shift_ff, wlen_ff);
   assign pos_inc = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      wlen_in   = wlen_ff;
      pos_in    = pos_ff;
      trim_in   = trim_ff;
      code_in   = code_ff;
      fail_in   = fail_ff;
      res       = '0;
      take      = 1'b0;
      success   = 1'b0;
      at_four   = (seen_ff == 3'd4);
      seen_in   = (seen_ff < 3'd5) ? seen_ff + 3'd1 : seen_ff;
      pos_wide  = {9'd0, pos_ff};
      trim_wide = '0;

      if (phase_ff == PH_PARAM) begin
         if (at_four && q_item.is_space) begin
            fail_in = 1'b1;
         end
         take = 1'b1;
      end else if (q_item.is_space || q_item.is_cr) begin
         if (!match.hit) begin
            fail_in = 1'b1;
         end else begin
            code_in = match.code;
         end
         phase_in = PH_PARAM;
         take     = q_item.is_cr;
      end else if (wlen_ff < 3'd5) begin
         shift_in = {shift_ff[23:0], q_item.line_byte};
         wlen_in  = wlen_ff + 3'd1;
      end

      if (take) begin
         if (pos_ff < PMAX) begin
            res.param_valid = 1'b1;
            res.param_byte  = q_item.line_byte;
            res.param_index = pos_wide[7:0];
         end
         if (!q_item.is_ws) begin
            trim_in = (pos_ff == PMAX_PLUS) ? PMAX_PLUS : pos_inc[PW-1:0];
         end
         if (pos_ff <= PMAX) begin
            pos_in = pos_inc[PW-1:0];
         end
      end

      trim_wide = {9'd0, trim_in};

      if (q_item.final_byte) begin
         res.done_res = 1'b1;
         priority if (seen_in < 3'd4) begin
            res.status = ST_MORE;
         end else if (phase_in == PH_WORD || fail_in) begin
            res.status = ST_FAIL;
         end else if (trim_in > PMAX) begin
            res.status = ST_LONG;
         end else begin
            res.status = ST_OK;
            success    = 1'b1;
         end
         if (success) begin
            res.command_code = code_in;
            res.param_length = trim_wide[8:0];
         end
         phase_in = PH_WORD;
         shift_in = '0;
         wlen_in  = '0;
         seen_in  = '0;
         pos_in   = '0;
         trim_in  = '0;
         code_in  = '0;
         fail_in  = 1'b0;
      end
   end

   always_comb begin
      owr_in  = q_pop ? ~owr_ff : owr_ff;
      ord_in  = out_pop ? ~ord_ff : ord_ff;
      ocnt_in = ocnt_ff + 2'(q_pop) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         oq_ff[owr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WORD;
         shift_ff <= '0;
         wlen_ff  <= '0;
         seen_ff  <= '0;
         pos_ff   <= '0;
         trim_ff  <= '0;
         code_ff  <= '0;
         fail_ff  <= 1'b0;
         owr_ff   <= 1'b0;
         ord_ff   <= 1'b0;
         ocnt_ff  <= '0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            wlen_ff  <= wlen_in;
            seen_ff  <= seen_in;
            pos_ff   <= pos_in;
            trim_ff  <= trim_in;
            code_ff  <= code_in;
            fail_ff  <= fail_in;
         end
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

endmodule

>>> hdl/ftp_command_line_parser_core.sv
`timescale 1ns / 1ps

// FTP request line parser. Feed the line one byte per item, with req_final_byte set on the
// last byte; every item gives exactly one result item, in order. The block sustains one item
// per clock cycle: a four-entry queue holds classified bytes, and the parser pops one per
// cycle while its two-entry result buffer has room or is being drained. A result passes
// through the input queue and then the result buffer to the result ports. Parameter bytes
// stream out with their index, and the result of the final byte carries status and, on
// success, command code and the parameter length with trailing spaces, CR and LF trimmed.

module ftp_command_line_parser_core import fclp_pkg::*; #(
   parameter int PARAM_MAX = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_line_byte,
   input  logic       req_final_byte,
   input  logic       push,
   output logic       full,
   output logic       rsp_param_valid,
   output logic [7:0] rsp_param_byte,
   output logic [7:0] rsp_param_index,
   output logic       rsp_done_res,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_command_code,
   output logic [8:0] rsp_param_length,
   output logic       empty,
   input  logic       pop
);

   logic            q_valid;
   logic            q_pop;
   fclp_item_type   q_item;
   fclp_result_type result;

   fclp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .line_byte  (req_line_byte),
      .final_byte (req_final_byte),
      .push       (push),
      .full       (full),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   fclp_back #(
      .PARAM_MAX (PARAM_MAX)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .result  (result)
   );

   assign rsp_param_valid  = result.param_valid;
   assign rsp_param_byte   = result.param_byte;
   assign rsp_param_index  = result.param_index;
   assign rsp_done_res     = result.done_res;
   assign rsp_status       = result.status;
   assign rsp_command_code = result.command_code;
   assign rsp_param_length = result.param_length;

endmodule

>>> dv/tb_ftp_command_line_parser_core.sv
`timescale 1ns / 1ps

module tb_ftp_command_line_parser_core;
   import fclp_pkg::*;

   localparam int PMAX        = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;

   localparam logic [31:0] VERBS [36] = '{
      "USER", "PASS", "PWD",  "CWD",  "LIST", "NLST", "PASV", "RETR", "STOR",
      "PORT", "TYPE", "MODE", "QUIT", "ABOR", "DELE", "RMD",  "XRMD", "MKD",
      "XMKD", "XPWD", "SYST", "REST", "RNFR", "RNTO", "STAT", "NOOP", "MDTM",
      "SIZE", "SITE", "FEAT", "OPTS", "feat", "opts", "syst", "site", "noop"
   };

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic [7:0] req_line_byte  = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       push           = 1'b0;
   logic       full;
   logic       rsp_param_valid;
   logic [7:0] rsp_param_byte;
   logic [7:0] rsp_param_index;
   logic       rsp_done_res;
   logic [1:0] rsp_status;
   logic [5:0] rsp_command_code;
   logic [8:0] rsp_param_length;
   logic       empty;
   logic       pop            = 1'b0;

   ftp_command_line_parser_core #(.PARAM_MAX(PMAX)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_line_byte    (req_line_byte),
      .req_final_byte   (req_final_byte),
      .push             (push),
      .full             (full),
      .rsp_param_valid  (rsp_param_valid),
      .rsp_param_byte   (rsp_param_byte),
      .rsp_param_index  (rsp_param_index),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .rsp_command_code (rsp_command_code),
      .rsp_param_length (rsp_param_length),
      .empty            (empty),
      .pop              (pop)
   );

   always #5 clock = ~clock;

   // Parser state as seen by the predictor.
   fclp_phase_type line_phase = PH_WORD;
   logic [31:0]    word_acc   = '0;
   int             word_len   = 0;
   int             bytes_in   = 0;
   int             param_pos  = 0;
   int             trim_len   = 0;
   logic [5:0]     verb_code  = '0;
   bit             line_bad   = 1'b0;

   fclp_result_type pending_results [$];
   logic [7:0]      line_q [$];
   int              mismatches = 0;
   int              items_sent = 0;
   int              burst_left = 0;
   int              cycles     = 0;
   bit              gaps_on    = 1'b1;
   bit              hold_rx    = 1'b0;

   task automatic clear_line_state();
      line_phase = PH_WORD;
      word_acc   = '0;
      word_len   = 0;
      bytes_in   = 0;
      param_pos  = 0;
      trim_len   = 0;
      verb_code  = '0;
      line_bad   = 1'b0;
   endtask

   task automatic take_param_byte(input logic [7:0] b, inout fclp_result_type r);
      if (param_pos < PMAX) begin
         r.param_valid = 1'b1;
         r.param_byte  = b;
         r.param_index = 8'(param_pos);
      end
      if (b != CHAR_SPACE && b != CHAR_CR && b != CHAR_LF) begin
         trim_len = (param_pos + 1 > PMAX + 1) ? PMAX + 1 : param_pos + 1;
      end
      if (param_pos <= PMAX) begin
         param_pos++;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fin, output fclp_result_type r);
      bit at_four;
      int hit;
      int n;
      at_four = (bytes_in == 4);
      r = '0;
      if (bytes_in < 5) begin
         bytes_in++;
      end
      if (line_phase == PH_PARAM) begin
         if (at_four && b == CHAR_SPACE) begin
            line_bad = 1'b1;
         end
         take_param_byte(b, r);
      end else if (b == CHAR_SPACE || b == CHAR_CR) begin
         hit = -1;
         if (word_len >= 1 && word_len <= 4) begin
            for (int i = 0; i < 36; i++) begin
               n = (VERBS[i][31:24] != 8'h00) ? 4 : 3;
               if (hit < 0 && n == word_len && VERBS[i] == word_acc) begin
                  hit = i;
               end
            end
         end
         if (hit < 0) begin
            line_bad = 1'b1;
         end else begin
            verb_code = 6'(hit);
         end
         line_phase = PH_PARAM;
         if (b == CHAR_CR) begin
            take_param_byte(b, r);
         end
      end else if (word_len < 5) begin
         word_acc = {word_acc[23:0], b};
         word_len++;
      end
      if (fin) begin
         r.done_res = 1'b1;
         if (bytes_in < 4) begin
            r.status = ST_MORE;
         end else if (line_phase == PH_WORD || line_bad) begin
            r.status = ST_FAIL;
         end else if (trim_len > PMAX) begin
            r.status = ST_LONG;
         end else begin
            r.status = ST_OK;
         end
         if (r.status == ST_OK) begin
            r.command_code = verb_code;
            r.param_length = 9'(trim_len);
         end
         clear_line_state();
      end
   endtask

   function automatic void check_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      fclp_result_type e;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result item arrived with none expected", $time);
            mismatches++;
         end else begin
            e = pending_results.pop_front();
            check_field("param_valid", e.param_valid, rsp_param_valid);
            check_field("param_byte", e.param_byte, rsp_param_byte);
            check_field("param_index", e.param_index, rsp_param_index);
            check_field("done_res", e.done_res, rsp_done_res);
            check_field("status", e.status, rsp_status);
            check_field("command_code", e.command_code, rsp_command_code);
            check_field("param_length", e.param_length, rsp_param_length);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_ftp_command_line_parser_core: errors");
         $finish;
      end
   end

   // The receiver switches between several pop patterns and honors a long hold on request.
   initial begin : result_drain
      int mode;
      int run;
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(1, 40);
         repeat (run) begin
            if (hold_rx) begin
               pop <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_rx = 1'b0;
            end
            case (mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= ($urandom_range(0, 3) == 0);
               default: pop <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input logic fin);
      fclp_result_type r;
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
               push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      push           <= 1'b1;
      req_line_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (full);
      parse_byte(b, fin, r);
      pending_results.push_back(r);
      items_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_q.size(); i++) begin
         send_item(line_q[i], i == line_q.size() - 1);
      end
      line_q.delete();
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_q.push_back(s[i]);
      end
   endtask

   task automatic wait_for_results();
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_lines();
      // Lowercase alias ended by a carriage return, which becomes the first parameter byte.
      load_text("noop");
      line_q.push_back(CHAR_CR);
      line_q.push_back(CHAR_LF);
      send_line();
      load_text("AB");
      send_line();
      load_text("XYZW");
      send_line();
      // The word ends early and the byte at index four is a space.
      load_text("AB   x");
      send_line();
      load_text("RMD ");
      line_q.push_back(8'h00);
      line_q.push_back(8'hFF);
      line_q.push_back(CHAR_SPACE);
      line_q.push_back(CHAR_CR);
      line_q.push_back(CHAR_LF);
      send_line();
   endtask

   task automatic test_param_overflow();
      int lens [2];
      lens = '{256, 257};
      for (int t = 0; t < 2; t++) begin
         load_text("RETR ");
         repeat (lens[t]) line_q.push_back(8'($urandom_range(33, 126)));
         if (t == 0) begin
            repeat (3) line_q.push_back(CHAR_SPACE);
         end
         line_q.push_back(CHAR_CR);
         line_q.push_back(CHAR_LF);
         send_line();
      end
   endtask

   task automatic test_receiver_holdoff();
      gaps_on = 1'b0;
      hold_rx = 1'b1;
      load_text("STOR ");
      repeat (30) line_q.push_back(8'($urandom_range(33, 126)));
      line_q.push_back(CHAR_CR);
      line_q.push_back(CHAR_LF);
      send_line();
      gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      load_text("USER anonymous");
      line_q.push_back(CHAR_CR);
      line_q.push_back(CHAR_LF);
      send_line();
      wait_for_results();
      load_text("PASS guest");
      line_q.push_back(CHAR_CR);
      line_q.push_back(CHAR_LF);
      send_line();
   endtask

   task automatic test_random_lines(input int count);
      int stop_at;
      int kind;
      int n;
      logic [31:0] w;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            w = VERBS[$urandom_range(0, 35)];
            for (int k = 3; k >= 0; k--) begin
               if (w[8*k +: 8] != 8'h00) begin
                  line_q.push_back(w[8*k +: 8]);
               end
            end
            if ($urandom_range(0, 7) == 0) begin
               n = $urandom_range(0, line_q.size() - 1);
               line_q[n] = line_q[n] ^ 8'h20;
            end
            if ($urandom_range(0, 3) != 0) begin
               line_q.push_back(CHAR_SPACE);
               n = $urandom_range(0, 12);
               repeat (n) begin
                  if ($urandom_range(0, 9) == 0) begin
                     line_q.push_back(8'($urandom));
                  end else begin
                     line_q.push_back(8'($urandom_range(33, 126)));
                  end
               end
               repeat ($urandom_range(0, 2)) line_q.push_back(CHAR_SPACE);
            end
            case ($urandom_range(0, 5))
               0: line_q.push_back(CHAR_CR);
               1: line_q.push_back(CHAR_LF);
               2: ;
               default: begin
                  line_q.push_back(CHAR_CR);
                  line_q.push_back(CHAR_LF);
               end
            endcase
         end else if (kind < 9) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0: line_q.push_back(CHAR_SPACE);
                  1: line_q.push_back(CHAR_CR);
                  2: line_q.push_back(CHAR_LF);
                  default: line_q.push_back(8'($urandom_range(65, 90)));
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom));
         end
         send_line();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_lines();
      test_param_overflow();
      test_random_lines(300);
      test_receiver_holdoff();
      test_drain_pause();
      test_random_lines(300);
      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_ftp_command_line_parser_core: clean");
      end else begin
         $display("tb_ftp_command_line_parser_core: errors");
      end
      $finish;
   end

endmodule
